FILE: rtl/core/cfla_pkg.sv
// Shared constants and control types for the chunked free-list slot allocator.
package cfla_pkg;

   localparam int SLOTS_DEFAULT = 1024;

   localparam int REG_W     = 11;
   localparam int SLOT_W    = 10;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_LIMIT  = 1'd1;

   localparam logic [REG_W-1:0] CHUNK_RESET = 11'd16;
   localparam logic [REG_W-1:0] LIMIT_RESET = 11'd0;
   localparam logic [REG_W-1:0] COUNT_MAX   = 11'h7FF;

   localparam logic KIND_ALLOC = 1'b0;

   typedef struct packed {
      logic latch_req;
      logic do_release;
      logic start_fill;
      logic fill_step;
      logic commit;
      logic pop;
   } dp_cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic release_ok;
      logic limit_hit;
      logic list_empty;
      logic chunk_ok;
      logic fill_last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/core/cfla_if.sv
// Request and response channel interfaces of the slot allocator.
interface cfla_req_if;
   import cfla_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic              handle_present;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, kind, handle_present, slot, input ready);
   modport sink   (input valid, kind, handle_present, slot, output ready);
endinterface

interface cfla_rsp_if;
   import cfla_pkg::*;

   logic              valid;
   logic              ready;
   logic              granted;
   logic [SLOT_W-1:0] slot_out;
   logic [REG_W-1:0]  in_use;

   modport source (output valid, granted, slot_out, in_use, input ready);
   modport sink   (input valid, granted, slot_out, in_use, output ready);
endinterface

FILE: rtl/core/cfla_datapath.sv
// Datapath: link memory, free-list head, counters, config registers, response register.
module cfla_datapath #(
   parameter int SLOTS = cfla_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfla_pkg::dp_cmd_type           cmd,
   output cfla_pkg::dp_status_type        status,
   input  logic                           req_kind,
   input  logic                           req_handle_present,
   input  logic [cfla_pkg::SLOT_W-1:0]    req_slot,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_granted,
   output logic [cfla_pkg::SLOT_W-1:0]    rsp_slot_out,
   output logic [cfla_pkg::REG_W-1:0]     rsp_in_use,
   input  logic                           csr_we,
   input  logic [cfla_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cfla_pkg::REG_W-1:0]     csr_data
);
   import cfla_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LW = $clog2(SLOTS + 1);
   localparam int CW = ((LW > REG_W) ? LW : REG_W) + 1;

   localparam logic [LW-1:0] EMPTY = LW'(SLOTS);

   logic              kind_ff;
   logic              present_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic [REG_W-1:0] chunk_ff, chunk_in;
   logic [REG_W-1:0] limit_ff, limit_in;
   logic [LW-1:0]    head_ff, head_in;
   logic [LW-1:0]    prov_ff, prov_in;
   logic [REG_W-1:0] count_ff, count_in;
   logic [LW-1:0]    fill_idx_ff, fill_idx_in;
   logic [LW-1:0]    fill_end_ff, fill_end_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             granted_ff;
   logic [SLOT_W-1:0] slot_out_ff;
   logic [REG_W-1:0] in_use_ff;

   logic [LW-1:0] link_mem [SLOTS];
   logic [LW-1:0] rd_data_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [LW-1:0] mem_wdata;
   logic [REG_W-1:0] count_inc;
   logic [REG_W-1:0] count_dec;
   logic [CW-1:0]    prov_plus_chunk;

   assign count_inc       = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign count_dec       = (count_ff == '0) ? count_ff : count_ff - 1'b1;
   assign prov_plus_chunk = CW'(prov_ff) + CW'(chunk_ff);

   assign status.is_alloc   = (kind_ff == KIND_ALLOC);
   assign status.release_ok = present_ff && (CW'(slot_ff) < CW'(SLOTS));
   assign status.limit_hit  = (limit_ff != '0) && (count_ff >= limit_ff);
   assign status.list_empty = (head_ff == EMPTY);
   assign status.chunk_ok   = (chunk_ff != '0) && (prov_plus_chunk <= CW'(SLOTS));
   assign status.fill_last  = (fill_idx_ff == fill_end_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff    <= req_kind;
         present_ff <= req_handle_present;
         slot_ff    <= req_slot;
      end
   end

   // link memory, one write port and one registered read at the head
   assign mem_we    = cmd.do_release || cmd.fill_step;
   assign mem_waddr = cmd.fill_step ? fill_idx_ff[AW-1:0] : AW'(slot_ff);
   assign mem_wdata = cmd.fill_step ? ((fill_idx_ff == prov_ff) ? EMPTY : fill_idx_ff - 1'b1)
                                    : head_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (!status.list_empty) begin
         rd_data_ff <= link_mem[head_ff[AW-1:0]];
      end
   end

   always_comb begin
      chunk_in     = chunk_ff;
      limit_in     = limit_ff;
      head_in      = head_ff;
      prov_in      = prov_ff;
      count_in     = count_ff;
      fill_idx_in  = fill_idx_ff;
      fill_end_in  = fill_end_ff;
      rsp_valid_in = rsp_valid_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CHUNK_SIZE: begin
               chunk_in = csr_data;
            end
            CSR_USE_LIMIT: begin
               limit_in = csr_data;
            end
            default: begin
            end
         endcase
         head_in  = EMPTY;
         prov_in  = '0;
         count_in = '0;
      end else begin
         if (cmd.do_release) begin
            head_in  = LW'(slot_ff);
            count_in = count_dec;
         end
         if (cmd.start_fill) begin
            fill_idx_in = prov_ff;
            fill_end_in = LW'(prov_plus_chunk - 1'b1);
         end
         if (cmd.fill_step) begin
            fill_idx_in = fill_idx_ff + 1'b1;
            if (status.fill_last) begin
               head_in = fill_idx_ff;
               prov_in = LW'(prov_plus_chunk);
            end
         end
         if (cmd.commit && cmd.pop) begin
            head_in  = rd_data_ff;
            count_in = count_inc;
         end
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff     <= CHUNK_RESET;
         limit_ff     <= LIMIT_RESET;
         head_ff      <= EMPTY;
         prov_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chunk_ff     <= chunk_in;
         limit_ff     <= limit_in;
         head_ff      <= head_in;
         prov_ff      <= prov_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_idx_ff <= fill_idx_in;
      fill_end_ff <= fill_end_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         granted_ff  <= cmd.pop;
         slot_out_ff <= cmd.pop ? SLOT_W'(head_ff) : '0;
         in_use_ff   <= cmd.pop ? count_inc : count_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_granted  = granted_ff;
   assign rsp_slot_out = slot_out_ff;
   assign rsp_in_use   = in_use_ff;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && cmd.pop) |-> (head_ff != EMPTY))
      else $error("pop from empty free list");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> (fill_idx_ff <= fill_end_ff && CW'(fill_idx_ff) < CW'(SLOTS)))
      else $error("provisioning index out of range");

   a_fill_head: assert property (@(posedge clock) disable iff (reset)
      (cmd.fill_step && status.fill_last && !csr_we) |=> (head_ff == $past(fill_end_ff)))
      else $error("head not at top of new chunk");

endmodule

FILE: rtl/core/cfla_ctrl.sv
// Controller: sequences decode, chunk provisioning, pop and response load.
module cfla_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cfla_pkg::dp_status_type status,
   output cfla_pkg::dp_cmd_type    cmd
);
   import cfla_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DECIDE   = 3'd1;
   localparam logic [2:0] ST_FILL     = 3'd2;
   localparam logic [2:0] ST_FIN_POP  = 3'd3;
   localparam logic [2:0] ST_FIN_NONE = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!status.is_alloc) begin
               cmd.do_release = status.release_ok;
               state_in       = ST_FIN_NONE;
            end else if (status.limit_hit) begin
               state_in = ST_FIN_NONE;
            end else if (!status.list_empty) begin
               state_in = ST_FIN_POP;
            end else if (status.chunk_ok) begin
               cmd.start_fill = 1'b1;
               state_in       = ST_FILL;
            end else begin
               state_in = ST_FIN_NONE;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_FIN_POP, ST_FIN_NONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               cmd.pop    = (state_ff == ST_FIN_POP);
               req_ready  = 1'b1;
               if (req_valid) begin
                  cmd.latch_req = 1'b1;
                  state_in      = ST_DECIDE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_fill_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && !status.fill_last) |=> (state_ff == ST_FILL))
      else $error("provisioning sweep cut short");

   a_commit_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("response loaded while output register busy");

   a_ready_states: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE || cmd.commit))
      else $error("request accepted mid transaction");

endmodule

FILE: rtl/core/chunked_free_list_slot_allocator.sv
// Top level of the chunked free-list slot allocator.
//
//   channel    dir   handshake          payload
//   req_chan   in    valid/ready        kind, handle_present, slot
//   rsp_chan   out   valid/ready        granted, slot_out, in_use
//   csr_*      in    csr_we             csr_index, csr_data
//
// Release, null release, failed allocate and allocate from a nonempty list: decide, then finish.
// Allocate that provisions a chunk: decide, the link-write sweep over the chunk, decide again, finish.
// Pop rate is set by the registered read of the link memory.
// Synchronous reset; no memory clearing pass, links are written before they are read.
// rsp_ready low holds the finished transaction; one new request waits behind it.
module chunked_free_list_slot_allocator #(
   parameter int SLOTS = cfla_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   cfla_req_if.sink                       req_chan,
   cfla_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [cfla_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cfla_pkg::REG_W-1:0]     csr_data
);
   import cfla_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   cfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cfla_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_kind           (req_chan.kind),
      .req_handle_present (req_chan.handle_present),
      .req_slot           (req_chan.slot),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_granted        (rsp_chan.granted),
      .rsp_slot_out       (rsp_chan.slot_out),
      .rsp_in_use         (rsp_chan.in_use),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

endmodule

FILE: tb/sv/chunked_free_list_slot_allocator_tb.sv
// Self-checking testbench for the chunked free-list slot allocator: directed table, random traffic.
`timescale 1ns / 100ps

module chunked_free_list_slot_allocator_tb;
   import cfla_pkg::*;

   localparam int   SLOTS         = SLOTS_DEFAULT;
   localparam logic KIND_RELEASE  = 1'b1;
   localparam int   SETTLE_CYCLES = 4;
   localparam int   DRAIN_CYCLES  = 20;

   typedef struct packed {
      logic              kind;
      logic              handle_present;
      logic [SLOT_W-1:0] slot;
   } pool_req_type;

   typedef struct packed {
      logic              granted;
      logic [SLOT_W-1:0] slot_out;
      logic [REG_W-1:0]  in_use;
   } pool_rsp_type;

   typedef enum logic [1:0] {STEP_OP, STEP_OP_KNOWN, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type        what;
      pool_req_type         rq;
      pool_rsp_type         known;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [REG_W-1:0]     reg_val;
   } step_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_data;

   cfla_req_if req_bus ();
   cfla_rsp_if rsp_bus ();

   chunked_free_list_slot_allocator #(
      .SLOTS(SLOTS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // pool shadow
   logic [REG_W-1:0] cfg_chunk;
   logic [REG_W-1:0] cfg_limit;
   logic [REG_W-1:0] link_of [SLOTS];
   logic [REG_W-1:0] free_top;
   logic [REG_W-1:0] carved;
   logic [REG_W-1:0] live_count;

   pool_rsp_type      pool_replies [$];
   logic [SLOT_W-1:0] held_slots [$];
   int                fault_count = 0;
   bit                req_quiet   = 1'b0;
   bit                rsp_quiet   = 1'b0;

   step_type directed_steps [0:30] = '{
      '{STEP_OP_KNOWN, '{KIND_ALLOC, 1'b0, 10'd0}, '{1'b1, 10'd15, 11'd1}, '0, '0},
      '{STEP_OP_KNOWN, '{KIND_ALLOC, 1'b1, 10'd1023}, '{1'b1, 10'd14, 11'd2}, '0, '0},
      '{STEP_OP_KNOWN, '{KIND_RELEASE, 1'b0, 10'd1023}, '{1'b0, 10'd0, 11'd2}, '0, '0},
      '{STEP_OP_KNOWN, '{KIND_RELEASE, 1'b1, 10'd14}, '{1'b0, 10'd0, 11'd1}, '0, '0},
      '{STEP_OP_KNOWN, '{KIND_ALLOC, 1'b0, 10'd0}, '{1'b1, 10'd14, 11'd2}, '0, '0},
      '{STEP_OP, '{KIND_RELEASE, 1'b1, 10'd1023}, '0, '0, '0},
      '{STEP_OP, '{KIND_ALLOC, 1'b0, 10'd0}, '0, '0, '0},
      '{STEP_OP, '{KIND_RELEASE, 1'b1, 10'd0}, '0, '0, '0},
      '{STEP_OP, '{KIND_RELEASE, 1'b1, 10'd0}, '0, '0, '0},
      '{STEP_OP, '{KIND_ALLOC, 1'b1, 10'd512}, '0, '0, '0},
      '{STEP_OP, '{KIND_RELEASE, 1'b1, 10'd15}, '0, '0, '0},
      '{STEP_OP, '{KIND_RELEASE, 1'b1, 10'd1}, '0, '0, '0},
      '{STEP_CSR, '0, '0, CSR_CHUNK_SIZE, 11'd1},
      '{STEP_CSR, '0, '0, CSR_USE_LIMIT, 11'd1},
      '{STEP_OP_KNOWN, '{KIND_ALLOC, 1'b0, 10'd0}, '{1'b1, 10'd0, 11'd1}, '0, '0},
      '{STEP_OP_KNOWN, '{KIND_ALLOC, 1'b0, 10'd0}, '{1'b0, 10'd0, 11'd1}, '0, '0},
      '{STEP_OP_KNOWN, '{KIND_RELEASE, 1'b1, 10'd0}, '{1'b0, 10'd0, 11'd0}, '0, '0},
      '{STEP_OP_KNOWN, '{KIND_ALLOC, 1'b0, 10'd0}, '{1'b1, 10'd0, 11'd1}, '0, '0},
      '{STEP_CSR, '0, '0, CSR_CHUNK_SIZE, 11'd0},
      '{STEP_CSR, '0, '0, CSR_USE_LIMIT, 11'd0},
      '{STEP_OP_KNOWN, '{KIND_ALLOC, 1'b0, 10'd0}, '{1'b0, 10'd0, 11'd0}, '0, '0},
      '{STEP_OP_KNOWN, '{KIND_RELEASE, 1'b0, 10'd1023}, '{1'b0, 10'd0, 11'd0}, '0, '0},
      '{STEP_CSR, '0, '0, CSR_CHUNK_SIZE, 11'd2047},
      '{STEP_OP_KNOWN, '{KIND_ALLOC, 1'b0, 10'd0}, '{1'b0, 10'd0, 11'd0}, '0, '0},
      '{STEP_CSR, '0, '0, CSR_CHUNK_SIZE, 11'd1024},
      '{STEP_OP_KNOWN, '{KIND_ALLOC, 1'b0, 10'd0}, '{1'b1, 10'd1023, 11'd1}, '0, '0},
      '{STEP_OP_KNOWN, '{KIND_ALLOC, 1'b0, 10'd0}, '{1'b1, 10'd1022, 11'd2}, '0, '0},
      '{STEP_OP, '{KIND_RELEASE, 1'b1, 10'd1023}, '0, '0, '0},
      '{STEP_OP, '{KIND_RELEASE, 1'b0, 10'd0}, '0, '0, '0},
      '{STEP_CSR, '0, '0, CSR_USE_LIMIT, 11'd2047},
      '{STEP_OP_KNOWN, '{KIND_ALLOC, 1'b0, 10'd0}, '{1'b1, 10'd1023, 11'd1}, '0, '0}
   };

   function automatic void pool_clear();
      free_top   = REG_W'(SLOTS);
      carved     = '0;
      live_count = '0;
   endfunction

   function automatic pool_rsp_type pool_apply(pool_req_type rq);
      pool_rsp_type      rs;
      logic              ok;
      logic [SLOT_W-1:0] s;
      rs = '0;
      if (rq.kind == KIND_ALLOC) begin
         ok = (cfg_limit == '0) || (live_count < cfg_limit);
         if (ok && free_top >= SLOTS) begin
            if (cfg_chunk == '0 || int'(carved) + int'(cfg_chunk) > SLOTS) begin
               ok = 1'b0;
            end else begin
               for (int i = 0; i < int'(cfg_chunk); i++) begin
                  s          = SLOT_W'(int'(carved) + i);
                  link_of[s] = free_top;
                  free_top   = {1'b0, s};
               end
               carved = carved + cfg_chunk;
            end
         end
         if (ok && free_top < SLOTS) begin
            rs.granted  = 1'b1;
            rs.slot_out = free_top[SLOT_W-1:0];
            free_top    = link_of[free_top[SLOT_W-1:0]];
            if (live_count != COUNT_MAX) live_count = live_count + 1'b1;
         end
      end else if (rq.handle_present && int'(rq.slot) < SLOTS) begin
         link_of[rq.slot] = free_top;
         free_top         = {1'b0, rq.slot};
         if (live_count != '0) live_count = live_count - 1'b1;
      end
      rs.in_use = live_count;
      return rs;
   endfunction

   task automatic send_op(input pool_req_type rq, input bit use_known,
                          input pool_rsp_type known);
      int           gap;
      pool_rsp_type rs;
      if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : int'($urandom_range(0, 6));
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.kind           <= rq.kind;
      req_bus.handle_present <= rq.handle_present;
      req_bus.slot           <= rq.slot;
      do @(posedge clock); while (!req_bus.ready);
      rs = pool_apply(rq);
      pool_replies.push_back(use_known ? known : rs);
      if (rs.granted) held_slots.push_back(rs.slot_out);
   endtask

   // registers only change with the pool drained
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      req_bus.valid <= 1'b0;
      while (pool_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CHUNK_SIZE) begin
         cfg_chunk = val;
      end else begin
         cfg_limit = val;
      end
      pool_clear();
      held_slots.delete();
   endtask

   // mostly alloc/free of held slots; some null and unchecked frees
   task automatic pool_traffic(input int n_items, input int alloc_pct);
      pool_req_type rq;
      int           r;
      int           pick;
      repeat (n_items) begin
         r                 = $urandom_range(0, 99);
         rq.kind           = KIND_ALLOC;
         rq.handle_present = 1'($urandom_range(0, 1));
         rq.slot           = SLOT_W'($urandom_range(0, SLOTS - 1));
         if (r >= alloc_pct) begin
            rq.kind = KIND_RELEASE;
            if (r < alloc_pct + (100 - alloc_pct) * 3 / 4 && held_slots.size() != 0) begin
               pick              = $urandom_range(0, held_slots.size() - 1);
               rq.handle_present = 1'b1;
               rq.slot           = held_slots[pick];
               held_slots.delete(pick);
            end else begin
               rq.handle_present = r[0];
            end
         end
         send_op(rq, 1'b0, '0);
      end
   endtask

   initial begin
      pool_req_type     rq;
      logic [REG_W-1:0] lim;
      int               s;
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= CSR_CHUNK_SIZE;
      csr_data               <= '0;
      req_bus.valid          <= 1'b0;
      req_bus.kind           <= KIND_ALLOC;
      req_bus.handle_present <= 1'b0;
      req_bus.slot           <= '0;
      cfg_chunk = CHUNK_RESET;
      cfg_limit = LIMIT_RESET;
      pool_clear();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[k]) begin
         case (directed_steps[k].what)
            STEP_CSR: write_reg(directed_steps[k].reg_idx, directed_steps[k].reg_val);
            STEP_OP:  send_op(directed_steps[k].rq, 1'b0, '0);
            default:  send_op(directed_steps[k].rq, 1'b1, directed_steps[k].known);
         endcase
      end

      for (int p = 0; p < 9; p++) begin
         if (p == 4) begin
            // one big chunk, alloc heavy: runs into the capacity bound
            write_reg(CSR_CHUNK_SIZE, REG_W'($urandom_range(513, 560)));
            write_reg(CSR_USE_LIMIT, ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'd0);
            pool_traffic(640, 96);
         end else begin
            write_reg(CSR_CHUNK_SIZE, REG_W'(($urandom_range(0, 3) == 0) ?
                      $urandom_range(1, 64) : $urandom_range(1, 8)));
            case ($urandom_range(0, 4))
               0, 1:    lim = 11'd0;
               2, 3:    lim = REG_W'($urandom_range(1, 12));
               default: lim = ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'd2047;
            endcase
            write_reg(CSR_USE_LIMIT, lim);
            pool_traffic(70, 55);
         end
      end

      // double free at count zero loops the list on one slot; allocates keep popping it
      write_reg(CSR_CHUNK_SIZE, CHUNK_RESET);
      write_reg(CSR_USE_LIMIT, LIMIT_RESET);
      s                 = $urandom_range(0, SLOTS - 1);
      rq.kind           = KIND_RELEASE;
      rq.handle_present = 1'b1;
      rq.slot           = SLOT_W'(s);
      repeat (2) send_op(rq, 1'b0, '0);
      repeat (165) begin
         rq.kind           = KIND_ALLOC;
         rq.handle_present = 1'($urandom_range(0, 1));
         rq.slot           = SLOT_W'($urandom_range(0, SLOTS - 1));
         send_op(rq, 1'b0, '0);
      end
      rq.kind           = KIND_RELEASE;
      rq.handle_present = 1'b1;
      rq.slot           = SLOT_W'(s);
      repeat (3) send_op(rq, 1'b0, '0);

      req_bus.valid <= 1'b0;
      while (pool_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("chunked_free_list_slot_allocator_tb: done, clean");
      end else begin
         $display("chunked_free_list_slot_allocator_tb: done, errors");
      end
      $finish;
   end

   initial begin
      int           stall;
      pool_rsp_type want;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
         stall = rsp_quiet ? 0 : int'($urandom_range(0, 6));
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         if (pool_replies.size() == 0) begin
            $error("response transaction with no request outstanding");
            fault_count++;
         end else begin
            want = pool_replies.pop_front();
            if (rsp_bus.granted !== want.granted) begin
               $error("granted: expected %0d, actual %0d", want.granted, rsp_bus.granted);
               fault_count++;
            end
            if (rsp_bus.slot_out !== want.slot_out) begin
               $error("slot_out: expected %0d, actual %0d", want.slot_out, rsp_bus.slot_out);
               fault_count++;
            end
            if (rsp_bus.in_use !== want.in_use) begin
               $error("in_use: expected %0d, actual %0d", want.in_use, rsp_bus.in_use);
               fault_count++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("chunked_free_list_slot_allocator_tb: done, errors");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/cfla_pkg.sv
rtl/core/cfla_if.sv
rtl/core/cfla_datapath.sv
rtl/core/cfla_ctrl.sv
rtl/core/chunked_free_list_slot_allocator.sv
tb/sv/chunked_free_list_slot_allocator_tb.sv
